// ----- sv/assert_macros.svh -----
// Assertion macros used by the top level of the bilinear resize block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- sv/bir_pkg.sv -----
// Package for the bilinear resize block: widths, codes, state and command types.
`default_nettype none
package bir_pkg;

	localparam int unsigned DEF_MAX_SRC_WIDTH  = 512;
	localparam int unsigned DEF_MAX_SRC_HEIGHT = 512;

	localparam int unsigned COORD_W = 12;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned PIX_W   = 3 * CHAN_W;
	localparam int unsigned TDATA_W = 48;
	localparam int unsigned SIZE_W  = 10;
	localparam int unsigned STEP_W  = 26;
	localparam int unsigned CFG_W   = 26;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [SIZE_W-1:0] RST_SRC_WIDTH  = SIZE_W'(512);
	localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT = SIZE_W'(512);
	localparam logic [STEP_W-1:0] RST_STEP       = STEP_W'(65536);

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 2'd3;

	// Beat kinds on tuser
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// Neighbour codes: top-left, top-right, bottom-left, bottom-right
	localparam logic [1:0] NB_TL = 2'd0;
	localparam logic [1:0] NB_TR = 2'd1;
	localparam logic [1:0] NB_BL = 2'd2;
	localparam logic [1:0] NB_BR = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_CLAMP,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_HOR,
		ST_VER
	} bir_state_t;

	typedef struct packed {
		logic       wr_en;
		logic       latch;
		logic       mul_en;
		logic       clamp_en;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       cap_en;
		logic [1:0] cap_sel;
		logic       hor_en;
		logic       out_load;
	} bir_cmd_t;

	typedef struct packed {
		logic out_free;
	} bir_sts_t;

endpackage
`default_nettype wire

// ----- sv/bir_ctrl.sv -----
// Controller of the bilinear resize block: issues pixel writes and sequences one sample through the datapath.
`default_nettype none
module bir_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          func,
	output logic               s_tready,
	input  bir_pkg::bir_sts_t  sts,
	output bir_pkg::bir_cmd_t  cmd
);

	bir_pkg::bir_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bir_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bir_pkg::ST_IDLE: begin
				if (s_tvalid && func == bir_pkg::FUNC_SAMPLE) state_nxt = bir_pkg::ST_MUL;
			end
			bir_pkg::ST_MUL:   state_nxt = bir_pkg::ST_CLAMP;
			bir_pkg::ST_CLAMP: state_nxt = bir_pkg::ST_RD0;
			bir_pkg::ST_RD0:   state_nxt = bir_pkg::ST_RD1;
			bir_pkg::ST_RD1:   state_nxt = bir_pkg::ST_RD2;
			bir_pkg::ST_RD2:   state_nxt = bir_pkg::ST_RD3;
			bir_pkg::ST_RD3:   state_nxt = bir_pkg::ST_HOR;
			bir_pkg::ST_HOR:   state_nxt = bir_pkg::ST_VER;
			bir_pkg::ST_VER: begin
				if (sts.out_free) state_nxt = bir_pkg::ST_IDLE;
			end
			default: state_nxt = bir_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			bir_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.wr_en = s_tvalid && func == bir_pkg::FUNC_WRITE;
				cmd.latch = s_tvalid && func == bir_pkg::FUNC_SAMPLE;
			end
			bir_pkg::ST_MUL:   cmd.mul_en = 1'b1;
			bir_pkg::ST_CLAMP: cmd.clamp_en = 1'b1;
			bir_pkg::ST_RD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = bir_pkg::NB_TL;
			end
			bir_pkg::ST_RD1: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = bir_pkg::NB_TR;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = bir_pkg::NB_TL;
			end
			bir_pkg::ST_RD2: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = bir_pkg::NB_BL;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = bir_pkg::NB_TR;
			end
			bir_pkg::ST_RD3: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = bir_pkg::NB_BR;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = bir_pkg::NB_BL;
			end
			bir_pkg::ST_HOR: cmd.hor_en = 1'b1;
			bir_pkg::ST_VER: cmd.out_load = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/bir_dp.sv -----
// Datapath of the bilinear resize block: registers, frame memory, position and blend logic.
`default_nettype none
module bir_dp #(
	parameter int unsigned MAX_SRC_WIDTH  = bir_pkg::DEF_MAX_SRC_WIDTH,
	parameter int unsigned MAX_SRC_HEIGHT = bir_pkg::DEF_MAX_SRC_HEIGHT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bir_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic [bir_pkg::TDATA_W-1:0]   s_tdata,
	input  wire logic                          m_tready,
	output logic                               m_tvalid,
	output logic [bir_pkg::TDATA_W-1:0]        m_tdata,
	input  bir_pkg::bir_cmd_t                  cmd,
	output bir_pkg::bir_sts_t                  sts
);

	localparam int unsigned XW    = $clog2(MAX_SRC_WIDTH);
	localparam int unsigned YW    = $clog2(MAX_SRC_HEIGHT);
	localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = bir_pkg::COORD_W;
	localparam int unsigned SW    = bir_pkg::STEP_W;
	localparam int unsigned PW    = CW + 1 + SW;

	function automatic logic [15:0] eff_size(input logic [bir_pkg::SIZE_W-1:0] r,
			input logic [15:0] mx);
		logic [15:0] rr;
		rr = 16'(r);
		if (rr == 16'd0) return 16'd1;
		if (rr > mx) return mx;
		return rr;
	endfunction

	function automatic logic [15:0] clamp_idx(input logic signed [23:0] v,
			input logic [15:0] lim);
		if (v < 24'sd0) return 16'd0;
		if (v > $signed({8'd0, lim})) return lim;
		return v[15:0];
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [YW-1:0] y, input logic [XW-1:0] x);
		return AW'(y) * AW'(MAX_SRC_WIDTH) + AW'(x);
	endfunction

	// configuration
	logic [bir_pkg::SIZE_W-1:0] src_w_q, src_h_q;
	logic [SW-1:0]              x_step_q, y_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q  <= bir_pkg::RST_SRC_WIDTH;
			src_h_q  <= bir_pkg::RST_SRC_HEIGHT;
			x_step_q <= bir_pkg::RST_STEP;
			y_step_q <= bir_pkg::RST_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				bir_pkg::CFG_SRC_WIDTH:  src_w_q  <= cfg_data[bir_pkg::SIZE_W-1:0];
				bir_pkg::CFG_SRC_HEIGHT: src_h_q  <= cfg_data[bir_pkg::SIZE_W-1:0];
				bir_pkg::CFG_X_STEP:     x_step_q <= cfg_data[SW-1:0];
				bir_pkg::CFG_Y_STEP:     y_step_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	logic [15:0] eff_w, eff_h;
	assign eff_w = eff_size(src_w_q, 16'(MAX_SRC_WIDTH));
	assign eff_h = eff_size(src_h_q, 16'(MAX_SRC_HEIGHT));

	// input fields
	logic [CW-1:0] in_col, in_row;
	logic [bir_pkg::PIX_W-1:0] in_pix;
	assign in_col = s_tdata[CW-1:0];
	assign in_row = s_tdata[2*CW-1:CW];
	assign in_pix = s_tdata[2*CW+bir_pkg::PIX_W-1:2*CW];

	logic wr_ok;
	assign wr_ok = (16'(in_col) < eff_w) && (16'(in_row) < eff_h);

	// sample coordinates
	logic [CW-1:0] col_q, row_q;
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			col_q <= in_col;
			row_q <= in_row;
		end
	end

	// (2d+1)*step
	logic [PW-1:0] prod_x_q, prod_y_q;
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_x_q <= PW'({col_q, 1'b1}) * PW'(x_step_q);
			prod_y_q <= PW'({row_q, 1'b1}) * PW'(y_step_q);
		end
	end

	// position in 2^-17 units, floor, weights, edge clamp
	logic signed [PW:0] pos_x, pos_y;
	logic signed [23:0] ipx, ipy, ipx1, ipy1;
	assign pos_x = $signed({1'b0, prod_x_q}) - (PW+1)'(65536);
	assign pos_y = $signed({1'b0, prod_y_q}) - (PW+1)'(65536);
	assign ipx   = 24'($signed(pos_x[PW:17]));
	assign ipy   = 24'($signed(pos_y[PW:17]));
	assign ipx1  = ipx + 24'sd1;
	assign ipy1  = ipy + 24'sd1;

	logic [XW-1:0] x0_q, x1_q;
	logic [YW-1:0] y0_q, y1_q;
	logic [7:0]    wx_q, wy_q;
	logic [15:0]   cx0, cx1, cy0, cy1;
	assign cx0 = clamp_idx(ipx, eff_w - 16'd1);
	assign cx1 = clamp_idx(ipx1, eff_w - 16'd1);
	assign cy0 = clamp_idx(ipy, eff_h - 16'd1);
	assign cy1 = clamp_idx(ipy1, eff_h - 16'd1);

	always_ff @(posedge clk) begin
		if (cmd.clamp_en) begin
			x0_q <= cx0[XW-1:0];
			x1_q <= cx1[XW-1:0];
			y0_q <= cy0[YW-1:0];
			y1_q <= cy1[YW-1:0];
			wx_q <= pos_x[16:9];
			wy_q <= pos_y[16:9];
		end
	end

	// frame memory, one port
	logic [bir_pkg::PIX_W-1:0] mem [DEPTH];
	logic [bir_pkg::PIX_W-1:0] rdata_q;
	logic [AW-1:0]             rd_addr, mem_addr;
	logic                      mem_we;

	always_comb begin
		case (cmd.rd_sel)
			bir_pkg::NB_TL: rd_addr = addr_of(y0_q, x0_q);
			bir_pkg::NB_TR: rd_addr = addr_of(y0_q, x1_q);
			bir_pkg::NB_BL: rd_addr = addr_of(y1_q, x0_q);
			bir_pkg::NB_BR: rd_addr = addr_of(y1_q, x1_q);
			default:        rd_addr = addr_of(y0_q, x0_q);
		endcase
	end

	assign mem_we   = cmd.wr_en && wr_ok;
	assign mem_addr = mem_we ? addr_of(in_row[YW-1:0], in_col[XW-1:0]) : rd_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= in_pix;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// captured neighbours; the last one is used straight from the read register
	logic [bir_pkg::PIX_W-1:0] px_q [3];
	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			case (cmd.cap_sel)
				bir_pkg::NB_TL: px_q[0] <= rdata_q;
				bir_pkg::NB_TR: px_q[1] <= rdata_q;
				bir_pkg::NB_BL: px_q[2] <= rdata_q;
				default: ;
			endcase
		end
	end

	// horizontal blend, three colour lanes
	logic [8:0]  nwx, nwy;
	logic [15:0] top_c [3];
	logic [15:0] bot_c [3];
	logic [15:0] top_q [3];
	logic [15:0] bot_q [3];
	assign nwx = 9'd256 - 9'(wx_q);
	assign nwy = 9'd256 - 9'(wy_q);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			top_c[c] = 16'(px_q[0][8*c +: 8]) * 16'(nwx) + 16'(px_q[1][8*c +: 8]) * 16'(wx_q);
			bot_c[c] = 16'(px_q[2][8*c +: 8]) * 16'(nwx) + 16'(rdata_q[8*c +: 8]) * 16'(wx_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hor_en) begin
			top_q <= top_c;
			bot_q <= bot_c;
		end
	end

	// vertical blend, round to nearest, saturate
	logic [24:0] vsum [3];
	logic [8:0]  rnd  [3];
	logic [7:0]  chan [3];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			vsum[c] = 25'(top_q[c]) * 25'(nwy) + 25'(bot_q[c]) * 25'(wy_q) + 25'd32768;
			rnd[c]  = vsum[c][24:16];
			chan[c] = rnd[c][8] ? 8'hFF : rnd[c][7:0];
		end
	end

	// output register
	logic        m_tvalid_q;
	logic [47:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {chan[2], chan[1], chan[0], row_q, col_q};
		end
	end

	assign sts.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = m_tdata_q;

endmodule
`default_nettype wire

// ----- sv/bilinear_image_resize.sv -----
// Top level of the bilinear resize block: controller, datapath and checks.
//
// A beat with tuser = 0 stores one source pixel at (column, line) and is taken whenever the
// block is idle; it is dropped when it falls outside the configured source size. A beat with
// tuser = 1 samples the destination pixel (column, line) and yields one result beat.
// After acceptance a sample occupies the block through a position multiply, a floor and
// edge clamp, four reads of the single-port frame memory (one neighbour each), a horizontal
// blend and a vertical blend into the output register; no further beat is taken before it
// ends. A finished result waits in the output register; writes keep flowing meanwhile,
// but a further sample holds in its last cycle, with the input stalled, until that
// register is free. Size and step registers are to be written only while the block is
// idle, which the block itself does not enforce; the frame memory is not cleared, so only
// written pixels may be sampled.
`default_nettype none
`include "assert_macros.svh"
module bilinear_image_resize #(
	parameter int unsigned MAX_SRC_WIDTH  = bir_pkg::DEF_MAX_SRC_WIDTH,
	parameter int unsigned MAX_SRC_HEIGHT = bir_pkg::DEF_MAX_SRC_HEIGHT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bir_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// column[11:0], line[23:12], blue_in[31:24], green_in[39:32], red_in[47:40]
	input  wire logic [bir_pkg::TDATA_W-1:0]   s_tdata,
	// func[0]
	input  wire logic                          s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// out_column[11:0], out_line[23:12], blue_out[31:24], green_out[39:32], red_out[47:40]
	output logic [bir_pkg::TDATA_W-1:0]        m_tdata
);

	bir_pkg::bir_cmd_t cmd;
	bir_pkg::bir_sts_t sts;

	bir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.func     (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bir_dp #(
		.MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	logic wr_beat, smp_beat;
	assign wr_beat  = s_tvalid && s_tready && s_tuser == bir_pkg::FUNC_WRITE;
	assign smp_beat = s_tvalid && s_tready && s_tuser == bir_pkg::FUNC_SAMPLE;

	`ASSERT_IMPL(a_wr_on_beat, clk, arst_n, cmd.wr_en, wr_beat)
	`ASSERT_IMPL(a_port_shared, clk, arst_n, cmd.wr_en, !cmd.rd_en)
	`ASSERT_NEXT(a_busy_after_sample, clk, arst_n, smp_beat, !s_tready && !cmd.out_load)
	`ASSERT_IMPL(a_result_from_load, clk, arst_n, $rose(m_tvalid), $past(cmd.out_load))

endmodule
`default_nettype wire
